// File: hw/rtl/pps_pkg.sv
package pps_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int DUTY_W  = 12;
  localparam int CODE_W  = 13;
  localparam int CHAN_W  = 4;
  localparam int SUM_W   = 17;
  localparam int DCNT_W  = 5;
  localparam int QUO_W   = 16;
  localparam int DSTEP_W = 4;

  localparam logic [DUTY_W-1:0] FULL_SCALE = 12'hFFF;
  localparam logic [CODE_W-1:0] FLAG_CODE  = 13'd4096;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic rd;
    logic advance;
  } pps_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_item;
  } pps_stat_t;

  function automatic logic is_dimmed(input logic [DUTY_W-1:0] d);
    is_dimmed = (d != '0) && (d != FULL_SCALE);
  endfunction

endpackage

// File: hw/rtl/pps_in_if.sv
interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::DUTY_W-1:0]  duty_value;
  logic                        last_value;

  modport source (output valid, output duty_value, output last_value, input ready);
  modport sink   (input valid, input duty_value, input last_value, output ready);
endinterface

// File: hw/rtl/pps_out_if.sv
interface pps_out_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::CHAN_W-1:0]  channel;
  logic [pps_pkg::CODE_W-1:0]  on_count;
  logic [pps_pkg::CODE_W-1:0]  off_count;
  logic                        last_channel;

  modport source (output valid, output channel, output on_count, output off_count,
                  output last_channel, input ready);
  modport sink   (input valid, input channel, input on_count, input off_count,
                  input last_channel, output ready);
endinterface

// File: hw/rtl/pps_ctrl.sv
module pps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pps_pkg::pps_stat_t status,
  output pps_pkg::pps_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_LOAD) && in_valid && in_ready_r;
    cmd.div_init = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.rd       = (state_r == ST_READ);
    cmd.advance  = (state_r == ST_EMIT) && out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_valid && in_ready_r && in_last) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (status.div_done) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_nxt = status.last_item ? ST_LOAD : ST_READ;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == ST_LOAD);
      out_valid_r <= (state_nxt == ST_EMIT);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input and output open together");
  a_div_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && status.div_done |=> (state_r == ST_READ))
    else $error("divide end not followed by read");
  a_read_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r)
    else $error("read not followed by result");
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance && status.last_item |=> in_ready_r && !out_valid_r)
    else $error("run end did not reopen input");
`endif

endmodule

// File: hw/rtl/pps_dpath.sv
module pps_dpath #(
  parameter int MAX_CHANNELS = pps_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pps_pkg::pps_cmd_t           cmd,
  output pps_pkg::pps_stat_t          status,
  input  logic [pps_pkg::DUTY_W-1:0]  in_duty,
  output logic [pps_pkg::CHAN_W-1:0]  out_channel,
  output logic [pps_pkg::CODE_W-1:0]  out_on,
  output logic [pps_pkg::CODE_W-1:0]  out_off,
  output logic                        out_last
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DW    = pps_pkg::DUTY_W;

  logic [DW-1:0]                  store [MAX_CHANNELS];
  logic [CNT_W-1:0]               loaded_r;
  logic [pps_pkg::SUM_W-1:0]      sum_r;
  logic [pps_pkg::DCNT_W-1:0]     dcnt_r;
  logic [pps_pkg::QUO_W-1:0]      quo_r;
  logic [pps_pkg::DCNT_W-1:0]     rem_r;
  logic                           neg_r;
  logic [pps_pkg::DSTEP_W-1:0]    dstep_r;
  logic [DW-1:0]                  overlap_r;
  logic [DW-1:0]                  phase_r;
  logic [IDX_W-1:0]               k_r;
  logic [DW-1:0]                  rd_r;

  logic                           room;
  logic                           clear;
  logic [pps_pkg::SUM_W-1:0]      mag;
  logic [pps_pkg::DCNT_W:0]       trial;
  logic                           take;
  logic [DW-1:0]                  quo_lo;
  logic                           dimmed;
  logic [DW-1:0]                  off_sum;

  assign room  = loaded_r < CNT_W'(MAX_CHANNELS);
  assign clear = cmd.advance && status.last_item;
  assign mag   = (sum_r >= pps_pkg::SUM_W'(pps_pkg::FULL_SCALE))
               ? sum_r - pps_pkg::SUM_W'(pps_pkg::FULL_SCALE)
               : pps_pkg::SUM_W'(pps_pkg::FULL_SCALE) - sum_r;
  assign trial = {rem_r, quo_r[pps_pkg::QUO_W-1]};
  assign take  = trial >= {1'b0, dcnt_r};
  assign quo_lo = quo_r[DW-1:0];

  assign status.div_done  = (dstep_r == '1);
  assign status.last_item = (CNT_W'(k_r) + CNT_W'(1)) == loaded_r;

  always_ff @(posedge clk) begin
    if (cmd.load && room) store[loaded_r[IDX_W-1:0]] <= in_duty;
    if (cmd.rd) rd_r <= store[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      sum_r    <= '0;
      dcnt_r   <= '0;
      phase_r  <= '0;
    end else begin
      if (cmd.load && room) begin
        loaded_r <= loaded_r + CNT_W'(1);
        if (pps_pkg::is_dimmed(in_duty)) begin
          sum_r  <= sum_r + pps_pkg::SUM_W'(in_duty);
          dcnt_r <= dcnt_r + pps_pkg::DCNT_W'(1);
        end
      end
      if (cmd.div_init) phase_r <= '0;
      if (cmd.advance && dimmed) phase_r <= off_sum - overlap_r;
      if (clear) begin
        loaded_r <= '0;
        sum_r    <= '0;
        dcnt_r   <= '0;
        phase_r  <= '0;
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r   <= mag[pps_pkg::QUO_W-1:0];
      neg_r   <= sum_r < pps_pkg::SUM_W'(pps_pkg::FULL_SCALE);
      rem_r   <= '0;
      dstep_r <= '0;
      k_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r   <= take ? pps_pkg::DCNT_W'(trial - {1'b0, dcnt_r})
                      : trial[pps_pkg::DCNT_W-1:0];
      quo_r   <= {quo_r[pps_pkg::QUO_W-2:0], take};
      dstep_r <= dstep_r + pps_pkg::DSTEP_W'(1);
    end
    if (cmd.rd) overlap_r <= (dcnt_r == '0) ? '0 : (neg_r ? DW'(0) - quo_lo : quo_lo);
    if (cmd.advance) k_r <= k_r + IDX_W'(1);
  end

  assign dimmed  = pps_pkg::is_dimmed(rd_r);
  assign off_sum = rd_r + phase_r;

  always_comb begin
    if (dimmed) begin
      out_on  = {1'b0, phase_r};
      out_off = {1'b0, off_sum};
    end else if (rd_r == '0) begin
      out_on  = '0;
      out_off = pps_pkg::FLAG_CODE;
    end else begin
      out_on  = pps_pkg::FLAG_CODE;
      out_off = '0;
    end
  end

  assign out_channel = pps_pkg::CHAN_W'(k_r);
  assign out_last    = status.last_item;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_CHANNELS) && dcnt_r <= pps_pkg::DCNT_W'(loaded_r))
    else $error("channel counts out of range");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> loaded_r == '0 && sum_r == '0 && dcnt_r == '0)
    else $error("run state not cleared");
  a_dimmed_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (dcnt_r == '0) == (sum_r == '0))
    else $error("dimmed sum and count disagree");
`endif

endmodule

// File: hw/rtl/pwm_phase_spread_unit.sv
// Staggered PWM phase planner. Duty requests load one per cycle; the request
// flagged last closes the set, after which the input stalls for a setup
// step, the shared bit-serial divider that forms the overlap, and then for
// each result a registered read of the duty store and the result itself,
// which waits while the output stalls. Results come out in load order, one
// per channel; requests beyond MAX_CHANNELS are dropped but their last flag
// still counts.
module pwm_phase_spread_unit #(
  parameter int MAX_CHANNELS = pps_pkg::MAX_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_chan,
  pps_out_if.source out_chan
);

  pps_pkg::pps_cmd_t  cmd;
  pps_pkg::pps_stat_t status;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_value),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pps_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_duty     (in_chan.duty_value),
    .out_channel (out_chan.channel),
    .out_on      (out_chan.on_count),
    .out_off     (out_chan.off_count),
    .out_last    (out_chan.last_channel)
  );

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES         = pps_pkg::MAX_CHANNELS_DEF;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 455;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 60;

  typedef struct packed {
    logic [pps_pkg::CHAN_W-1:0] channel;
    logic [pps_pkg::CODE_W-1:0] on_count;
    logic [pps_pkg::CODE_W-1:0] off_count;
    logic                       last_channel;
  } phase_plan_t;

  typedef struct packed {
    logic [pps_pkg::DUTY_W-1:0] duty;
    logic                       last;
    logic                       typed;
    logic [pps_pkg::CODE_W-1:0] on_count;
    logic [pps_pkg::CODE_W-1:0] off_count;
  } duty_row_t;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_STARVED
  } sink_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pps_in_if  in_bus();
  pps_out_if out_bus();

  pwm_phase_spread_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first dimmed channel of a set always starts at 0 and ends at its duty
  duty_row_t directed_rows [DIRECTED_ROWS] = '{
    '{12'd0,    1'b1, 1'b1, 13'd0,    13'd4096},
    '{12'd4095, 1'b1, 1'b1, 13'd4096, 13'd0},
    '{12'd1,    1'b0, 1'b1, 13'd0,    13'd1},
    '{12'd4094, 1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd0,    1'b0, 1'b1, 13'd0,    13'd4096},
    '{12'd4095, 1'b1, 1'b1, 13'd4096, 13'd0},
    '{12'd2048, 1'b0, 1'b1, 13'd0,    13'd2048},
    '{12'd4000, 1'b1, 1'b0, 13'd0,    13'd0},
    // 17 requests: the last one is dropped, its flag still closes the set
    '{12'd3,    1'b0, 1'b1, 13'd0,    13'd3},
    '{12'd0,    1'b0, 1'b1, 13'd0,    13'd4096},
    '{12'd4095, 1'b0, 1'b1, 13'd4096, 13'd0},
    '{12'd10,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd20,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd30,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd40,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd50,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd60,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd70,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd80,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd90,   1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd100,  1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd200,  1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd300,  1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd400,  1'b0, 1'b0, 13'd0,    13'd0},
    '{12'd4095, 1'b1, 1'b0, 13'd0,    13'd0}
  };

  phase_plan_t                expected_plans [$];
  logic [pps_pkg::DUTY_W-1:0] plan_duty [LANES];
  int                         plan_loaded;
  int                         plan_dim_sum;
  int                         plan_dim_cnt;

  bit                         typed_mask [LANES];
  logic [pps_pkg::CODE_W-1:0] typed_on   [LANES];
  logic [pps_pkg::CODE_W-1:0] typed_off  [LANES];

  int fail_count;
  int sent_count;
  int burst_left;
  bit quiet_mode;
  int hold_requests;

  function automatic void plan_request(input logic [pps_pkg::DUTY_W-1:0] duty,
                                       input logic last);
    logic [pps_pkg::DUTY_W-1:0] overlap;
    logic [pps_pkg::DUTY_W-1:0] phase;
    logic [pps_pkg::DUTY_W-1:0] off_pos;
    logic [pps_pkg::DUTY_W-1:0] d;
    int                         num;
    phase_plan_t                p;
    if (plan_loaded < LANES) begin
      plan_duty[plan_loaded] = duty;
      plan_loaded++;
      if (duty != '0 && duty != pps_pkg::FULL_SCALE) begin
        plan_dim_sum += duty;
        plan_dim_cnt++;
      end
    end
    if (!last) return;
    overlap = '0;
    if (plan_dim_cnt != 0) begin
      num = plan_dim_sum - int'(pps_pkg::FULL_SCALE);
      overlap = pps_pkg::DUTY_W'(num / plan_dim_cnt);
    end
    phase = '0;
    for (int k = 0; k < plan_loaded; k++) begin
      d = plan_duty[k];
      p.channel = pps_pkg::CHAN_W'(k);
      p.last_channel = (k == plan_loaded - 1);
      if (d != '0 && d != pps_pkg::FULL_SCALE) begin
        off_pos = d + phase;
        p.on_count = {1'b0, phase};
        p.off_count = {1'b0, off_pos};
        phase = off_pos - overlap;
      end else if (d == '0) begin
        p.on_count = '0;
        p.off_count = pps_pkg::FLAG_CODE;
      end else begin
        p.on_count = pps_pkg::FLAG_CODE;
        p.off_count = '0;
      end
      if (typed_mask[k]) begin
        p.on_count = typed_on[k];
        p.off_count = typed_off[k];
      end
      expected_plans.push_back(p);
    end
    plan_loaded = 0;
    plan_dim_sum = 0;
    plan_dim_cnt = 0;
  endfunction

  task automatic send_request(input logic [pps_pkg::DUTY_W-1:0] duty, input logic last);
    int gap;
    in_bus.valid <= 1'b1;
    in_bus.duty_value <= duty;
    in_bus.last_value <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    plan_request(duty, last);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = quiet_mode ? 0 : $urandom_range(0, 8);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_set(input int size, input bit small_only);
    logic [pps_pkg::DUTY_W-1:0] duty;
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(0, 9))
        0:       duty = '0;
        1:       duty = pps_pkg::FULL_SCALE;
        2, 3:    duty = pps_pkg::DUTY_W'($urandom_range(1, 15));
        4:       duty = pps_pkg::DUTY_W'($urandom_range(4080, 4094));
        default: duty = pps_pkg::DUTY_W'(small_only ? $urandom_range(1, 400)
                                                    : $urandom_range(0, 4095));
      endcase
      send_request(duty, i == size - 1);
    end
  endtask

  task automatic pause_until_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_plans.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input logic [pps_pkg::CHAN_W-1:0] chan, input string what,
                              input logic [pps_pkg::CODE_W-1:0] want,
                              input logic [pps_pkg::CODE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: channel %0d %s expected %0d got %0d", $time, chan, what, want, got);
      fail_count++;
    end
  endtask

  initial begin : request_source
    int set_pos;
    int set_idx;
    int phase_slot;
    int r;
    int size;
    in_bus.valid <= 1'b0;
    in_bus.duty_value <= '0;
    in_bus.last_value <= 1'b0;
    plan_loaded = 0;
    plan_dim_sum = 0;
    plan_dim_cnt = 0;
    fail_count = 0;
    sent_count = 0;
    burst_left = 0;
    quiet_mode = 1'b0;
    hold_requests = 0;
    typed_mask = '{default: 1'b0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_pos = 0;
    foreach (directed_rows[i]) begin
      if (set_pos == 0) typed_mask = '{default: 1'b0};
      if (directed_rows[i].typed && set_pos < LANES) begin
        typed_mask[set_pos] = 1'b1;
        typed_on[set_pos] = directed_rows[i].on_count;
        typed_off[set_pos] = directed_rows[i].off_count;
      end
      send_request(directed_rows[i].duty, directed_rows[i].last);
      set_pos = directed_rows[i].last ? 0 : set_pos + 1;
    end
    typed_mask = '{default: 1'b0};
    pause_until_drained();

    set_idx = 0;
    while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
      phase_slot = set_idx % 10;
      if (phase_slot == 7) pause_until_drained();
      // long output hold-off while requests keep coming
      if (phase_slot == 3) hold_requests++;
      quiet_mode = (phase_slot == 3) || (phase_slot == 4) || ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      if (phase_slot == 3) size = LANES;
      else if (r < 2) size = $urandom_range(LANES + 1, LANES + 4);
      else if (r < 6) size = LANES;
      else size = $urandom_range(1, LANES - 1);
      send_random_set(size, $urandom_range(0, 3) == 0);
      set_idx++;
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pwm_phase_spread_unit regression: pass");
    end else begin
      $display("pwm_phase_spread_unit regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    phase_plan_t want;
    sink_mode_t  mode;
    int          mode_left;
    int          hold_left;
    int          hold_served;
    logic        grant;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_served = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (expected_plans.size() == 0) begin
          $display("%0t: unexpected result channel %0d on %0d off %0d", $time,
                   out_bus.channel, out_bus.on_count, out_bus.off_count);
          fail_count++;
        end else begin
          want = expected_plans.pop_front();
          report_field(want.channel, "channel", pps_pkg::CODE_W'(want.channel),
                       pps_pkg::CODE_W'(out_bus.channel));
          report_field(want.channel, "on_count", want.on_count, out_bus.on_count);
          report_field(want.channel, "off_count", want.off_count, out_bus.off_count);
          report_field(want.channel, "last_channel", pps_pkg::CODE_W'(want.last_channel),
                       pps_pkg::CODE_W'(out_bus.last_channel));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        grant = 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:    grant = 1'b1;
          SINK_RANDOM:  grant = 1'($urandom_range(0, 1));
          SINK_PATTERN: grant = (mode_left % 4 == 0);
          default:      grant = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_bus.ready <= grant;
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("pwm_phase_spread_unit regression: fail");
    $finish;
  end

endmodule
